>>> sv/b7f_pkg.sv
// Shared types and constants for the signed base-7 ASCII formatter.
`timescale 1ns / 1ps

package b7f_pkg;

   localparam int CHUNK_BITS  = 8;
   localparam int STORE_DEPTH = 23;
   localparam int COUNT_BITS  = 5;

   localparam logic [5:0]  DIGIT_BASE = 6'd48;
   localparam logic [5:0]  MINUS_CODE = 6'd45;
   localparam logic [2:0]  RADIX      = 3'd7;

   // floor(x * RECIP_MULT / 2^RECIP_SHIFT) equals floor(x / 7) for every x below 1792.
   localparam logic [15:0] RECIP_MULT  = 16'd37450;
   localparam int          RECIP_SHIFT = 18;

   typedef struct packed {
      logic       valid;
      logic       zero;
      logic [2:0] rem;
   } div_link_type;

   typedef struct packed {
      logic push;
      logic pop;
   } stack_ctl_type;

endpackage

>>> sv/b7f_div_cell.sv
// One byte-wide stage of the systolic repeated divide-by-seven chain.
`timescale 1ns / 1ps

module b7f_div_cell
   import b7f_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  logic [CHUNK_BITS-1:0] load_chunk,
   input  div_link_type          link_in,
   output div_link_type          link_out
);

   logic [CHUNK_BITS-1:0] chunk_ff;
   logic [CHUNK_BITS-1:0] chunk_in;
   div_link_type          link_ff;
   div_link_type          link_in_next;
   logic [CHUNK_BITS+2:0] dividend;
   logic [CHUNK_BITS+18:0] product;
   logic [CHUNK_BITS-1:0] quot;
   logic [CHUNK_BITS+2:0] rem_wide;

   assign dividend = {link_in.rem, chunk_ff};
   assign product  = (CHUNK_BITS + 19)'(dividend) * (CHUNK_BITS + 19)'(RECIP_MULT);
   assign quot     = product[RECIP_SHIFT +: CHUNK_BITS];
   assign rem_wide = dividend - ((CHUNK_BITS + 3)'(quot) * (CHUNK_BITS + 3)'(RADIX));

   always_comb begin
      chunk_in = chunk_ff;
      link_in_next.valid = link_in.valid;
      link_in_next.zero  = link_in.zero && (quot == '0);
      link_in_next.rem   = rem_wide[2:0];
      if (load) begin
         chunk_in = load_chunk;
         link_in_next.valid = 1'b0;
      end else if (link_in.valid) begin
         chunk_in = quot;
      end
   end

   always_ff @(posedge clock) begin
      chunk_ff <= chunk_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff <= '0;
      end else begin
         link_ff <= link_in_next;
      end
   end

   assign link_out = link_ff;

endmodule

>>> sv/b7f_digit_cell.sv
// One entry of the digit stack; pushes shift up from below, pops shift down from above.
`timescale 1ns / 1ps

module b7f_digit_cell
   import b7f_pkg::*;
(
   input  logic          clock,
   input  stack_ctl_type ctl,
   input  logic [2:0]    below_digit,
   input  logic [2:0]    above_digit,
   output logic [2:0]    digit
);

   logic [2:0] digit_ff;
   logic [2:0] digit_in;

   always_comb begin
      digit_in = digit_ff;
      if (ctl.push) begin
         digit_in = below_digit;
      end else if (ctl.pop) begin
         digit_in = above_digit;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   assign digit = digit_ff;

endmodule

>>> sv/signed_base7_ascii_formatter.sv
// Top level of the signed base-7 ASCII formatter: control, division chain and digit stack.
// Each accepted item is a signed WORD_BITS-bit value in the low bits of req_value; the block
// returns its base-7 text one ASCII character per item on the rsp channel, a leading minus for
// negative values, most significant digit first, with rsp_is_last set on the final character.
// One value is handled at a time. The magnitude is divided by seven in a chain of byte-wide
// stages, (WORD_BITS+7)/8 of them, through which a wavefront carries the remainder, so the
// digits emerge least significant first and are pushed onto a stack; the characters then
// leave at one per cycle while the rsp side does not hold stall.
`timescale 1ns / 1ps

module signed_base7_ascii_formatter
   import b7f_pkg::*;
#(
   parameter int WORD_BITS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_character,
   output logic        rsp_is_last
);

   localparam int CELLS    = (WORD_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
   localparam int MAG_BITS = CELLS * CHUNK_BITS;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type             state_ff, state_in;
   logic                  sign_pending_ff, sign_pending_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [5:0]            rsp_character_ff, rsp_character_in;
   logic                  rsp_is_last_ff, rsp_is_last_in;

   logic [WORD_BITS-1:0]  raw;
   logic                  negative;
   logic [WORD_BITS-1:0]  mag;
   logic [MAG_BITS-1:0]   mag_ext;
   logic                  load;
   logic                  slot_free;

   div_link_type          link_chain [CELLS+1];
   div_link_type          tail;
   stack_ctl_type         stack_ctl;
   logic [2:0]            digit_chain [STORE_DEPTH];

   assign raw      = req_value[WORD_BITS-1:0];
   assign negative = raw[WORD_BITS-1];
   assign mag      = negative ? (~raw + WORD_BITS'(1)) : raw;
   assign mag_ext  = MAG_BITS'(mag);
   assign load     = (state_ff == ST_IDLE) && req_valid;

   assign link_chain[0].valid = (state_ff == ST_DIV);
   assign link_chain[0].zero  = 1'b1;
   assign link_chain[0].rem   = 3'd0;
   assign tail = link_chain[CELLS];

   for (genvar j = 0; j < CELLS; j++) begin : gen_div
      b7f_div_cell u_div (
         .clock      (clock),
         .reset      (reset),
         .load       (load),
         .load_chunk (mag_ext[(CELLS-1-j)*CHUNK_BITS +: CHUNK_BITS]),
         .link_in    (link_chain[j]),
         .link_out   (link_chain[j+1])
      );
   end

   for (genvar i = 0; i < STORE_DEPTH; i++) begin : gen_stack
      logic [2:0] below;
      logic [2:0] above;
      if (i == 0) begin : g_bottom
         assign below = tail.rem;
      end else begin : g_inner_below
         assign below = digit_chain[i-1];
      end
      if (i == STORE_DEPTH - 1) begin : g_top
         assign above = 3'd0;
      end else begin : g_inner_above
         assign above = digit_chain[i+1];
      end
      b7f_digit_cell u_digit (
         .clock       (clock),
         .ctl         (stack_ctl),
         .below_digit (below),
         .above_digit (above),
         .digit       (digit_chain[i])
      );
   end

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in         = state_ff;
      sign_pending_in  = sign_pending_ff;
      count_in         = count_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_character_in = rsp_character_ff;
      rsp_is_last_in   = rsp_is_last_ff;
      stack_ctl.push   = 1'b0;
      stack_ctl.pop    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               sign_pending_in = negative;
               count_in        = '0;
               state_in        = ST_DIV;
            end
         end
         ST_DIV: begin
            if (tail.valid) begin
               stack_ctl.push = 1'b1;
               count_in       = count_ff + COUNT_BITS'(1);
               if (tail.zero || (count_ff == COUNT_BITS'(STORE_DEPTH - 1))) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (sign_pending_ff) begin
                  rsp_character_in = MINUS_CODE;
                  rsp_is_last_in   = 1'b0;
                  sign_pending_in  = 1'b0;
               end else begin
                  rsp_character_in = DIGIT_BASE + {3'b000, digit_chain[0]};
                  rsp_is_last_in   = (count_ff == COUNT_BITS'(1));
                  stack_ctl.pop    = 1'b1;
                  count_in         = count_ff - COUNT_BITS'(1);
                  if (count_ff == COUNT_BITS'(1)) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         sign_pending_ff <= 1'b0;
         count_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         sign_pending_ff <= sign_pending_in;
         count_ff        <= count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_character_ff <= rsp_character_in;
      rsp_is_last_ff   <= rsp_is_last_in;
   end

   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_is_last   = rsp_is_last_ff;

   a_emit_has_digits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (count_ff != '0))
      else $error("Emitting with an empty digit stack.");

   a_push_pop_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(stack_ctl.push && stack_ctl.pop))
      else $error("Digit stack pushed and popped in the same cycle.");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(STORE_DEPTH))
      else $error("Digit count exceeds the stack depth.");

   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_character_ff == MINUS_CODE)) |-> !rsp_is_last_ff)
      else $error("A minus sign was marked as the last character of an item.");

   a_accept_starts_div: assert property (@(posedge clock) disable iff (reset)
      load |=> (state_ff == ST_DIV))
      else $error("An accepted item did not start division.");

endmodule
